>>> hdl/battery_soc_led_bar_controller_defines.svh
// Assertion macros for the battery SOC LED bar controller.
// Depends on nothing; files that check their own logic include it.
`ifndef BATTERY_SOC_LED_BAR_CONTROLLER_DEFINES_SVH
`define BATTERY_SOC_LED_BAR_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset.
`define BSLC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: invariant violated");
// Check that one condition implies another in the same cycle.
`define BSLC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication violated");
`else
`define BSLC_ASSERT_ALWAYS(lbl, cond)
`define BSLC_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

>>> hdl/bslc_pkg.sv
// Shared types, codes and helper functions of the battery SOC LED bar controller.
// Depends on nothing; every module of the block imports it.
package bslc_pkg;

  localparam int LED_W   = 5;
  localparam int SOC_W   = 7;
  localparam int MODE_W  = 2;
  localparam int BLINK_W = 3;
  localparam int ANIM_W  = 4;

  // Display mode codes
  localparam logic [MODE_W-1:0] MODE_STARTUP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHARGE    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DISCHARGE = 2'd3;

  localparam logic [SOC_W-1:0]   SOC_MAX       = 7'd100;
  localparam logic [BLINK_W-1:0] BLINK_TOP     = 3'd5;
  localparam logic [ANIM_W-1:0]  ANIM_BLANK_END = 4'd5;
  localparam logic [ANIM_W-1:0]  ANIM_FULL_END  = 4'd10;
  localparam logic [LED_W-1:0]   LED_ALL       = 5'h1F;
  localparam logic [LED_W-1:0]   LED_TOP       = 5'h10;

  typedef struct packed {
    logic             tick;
    logic             bms_starting;
    logic [SOC_W-1:0] soc_percent;
    logic             charge_active;
    logic             discharge_active;
    logic             cell_undervolt;
    logic             pack_undervolt;
  } bslc_item_t;

  typedef struct packed {
    logic [LED_W-1:0]  led_pattern;
    logic [MODE_W-1:0] display_mode;
  } bslc_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LED_W-1:0]   led;
    logic [BLINK_W-1:0] blink;
    logic [ANIM_W-1:0]  anim;
  } bslc_status_t;

  // Bar in 20 percent steps; the lowest LED lights at zero unless strict.
  function automatic logic [LED_W-1:0] bar_20_steps(input logic [SOC_W-1:0] soc,
                                                    input logic strict);
    logic [LED_W-1:0] p;
    p[0] = strict ? (soc != '0) : 1'b1;
    p[1] = (soc >= 7'd20);
    p[2] = (soc >= 7'd40);
    p[3] = (soc >= 7'd60);
    p[4] = (soc >= 7'd80);
    return p;
  endfunction

  // Mask that blanks the LED of the current 20 percent level; none at 100.
  function automatic logic [LED_W-1:0] blank_mask(input logic [SOC_W-1:0] soc);
    logic [LED_W-1:0] m;
    if (soc >= 7'd100) m = LED_ALL;
    else if (soc >= 7'd80) m = 5'h0F;
    else if (soc >= 7'd60) m = 5'h17;
    else if (soc >= 7'd40) m = 5'h1B;
    else if (soc >= 7'd20) m = 5'h1D;
    else m = 5'h1E;
    return m;
  endfunction

endpackage

>>> hdl/bslc_in_stage.sv
// Input register of the battery SOC LED bar controller.
// Depends on bslc_pkg for the request type.
module bslc_in_stage
  import bslc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  bslc_item_t in_item,
  input  logic       advance,
  output logic       in_stall,
  output logic       item_valid,
  output bslc_item_t item
);

  logic       valid_r, valid_nxt;
  bslc_item_t item_r;
  logic       load;

  // Stall only when a held request cannot move on this cycle.
  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> hdl/bslc_core.sv
// Mode machine and LED state of the battery SOC LED bar controller.
// Depends on bslc_pkg for codes, types and bar functions.
module bslc_core
  import bslc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  bslc_item_t   item,
  output bslc_result_t result_nxt,
  output bslc_status_t status
);

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [LED_W-1:0]   led_r, led_nxt;
  logic [BLINK_W-1:0] blink_r, blink_nxt;
  logic [ANIM_W-1:0]  anim_r, anim_nxt;
  logic [LED_W-1:0]   mask_r, mask_nxt;

  logic [SOC_W-1:0]   soc;
  logic               uv;
  logic [BLINK_W-1:0] blink_inc;
  logic [ANIM_W-1:0]  anim_inc1;
  logic [ANIM_W-1:0]  anim_inc2;

  always_comb begin
    soc       = (item.soc_percent > SOC_MAX) ? SOC_MAX : item.soc_percent;
    uv        = item.cell_undervolt || item.pack_undervolt;
    blink_inc = blink_r + 1'b1;
    anim_inc1 = anim_r + 1'b1;
    anim_inc2 = anim_inc1 + 1'b1;

    mode_nxt  = mode_r;
    led_nxt   = led_r;
    blink_nxt = blink_r;
    anim_nxt  = anim_r;
    mask_nxt  = mask_r;

    if (item.tick && !item.bms_starting) begin
      unique case (mode_r)
        MODE_STARTUP: begin
          mode_nxt = MODE_NORMAL;
        end
        MODE_NORMAL: begin
          if (uv) begin
            if (blink_inc >= BLINK_TOP) begin
              blink_nxt = '0;
              led_nxt   = {led_r[LED_W-1], 3'b000, ~led_r[0]};
            end else begin
              blink_nxt = blink_inc;
            end
          end else begin
            blink_nxt = '0;
            led_nxt   = {led_r[LED_W-1], (soc >= 7'd80), (soc >= 7'd50),
                         (soc >= 7'd25), (soc != '0)};
          end
          if (item.discharge_active) begin
            mode_nxt = MODE_DISCHARGE;
          end else if (item.charge_active) begin
            mode_nxt = MODE_CHARGE;
          end
        end
        MODE_CHARGE: begin
          // Blank the current level, then light everything, then restart.
          if (anim_inc1 <= ANIM_BLANK_END) begin
            anim_nxt = anim_inc1;
            mask_nxt = blank_mask(soc);
          end else if (anim_inc2 <= ANIM_FULL_END) begin
            anim_nxt = anim_inc2;
            mask_nxt = LED_ALL;
          end else begin
            anim_nxt = '0;
          end
          led_nxt = bar_20_steps(soc, 1'b0) & mask_nxt;
          if (!item.charge_active) begin
            led_nxt  = '0;
            mode_nxt = MODE_NORMAL;
          end
        end
        default: begin
          led_nxt = bar_20_steps(soc, 1'b1);
          if (!item.discharge_active) begin
            led_nxt  = '0;
            mode_nxt = MODE_NORMAL;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STARTUP;
      led_r   <= '0;
      blink_r <= '0;
      anim_r  <= '0;
      mask_r  <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      led_r   <= led_nxt;
      blink_r <= blink_nxt;
      anim_r  <= anim_nxt;
      mask_r  <= mask_nxt;
    end
  end

  assign result_nxt = '{led_pattern: led_nxt, display_mode: mode_nxt};
  assign status     = '{mode: mode_r, led: led_r, blink: blink_r, anim: anim_r};

endmodule

>>> hdl/bslc_out_stage.sv
// Result register of the battery SOC LED bar controller.
// Depends on bslc_pkg for the result type.
module bslc_out_stage
  import bslc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  input  bslc_result_t result_nxt,
  input  logic         out_stall,
  output logic         advance,
  output logic         out_valid,
  output bslc_result_t result
);

  logic         valid_r;
  bslc_result_t result_r;

  // Advance whenever the slot is empty or its request leaves now.
  assign advance = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = valid_r;
  assign result    = result_r;

endmodule

>>> hdl/battery_soc_led_bar_controller.sv
// Top level of the battery SOC LED bar controller.
// Depends on bslc_pkg, bslc_in_stage, bslc_core, bslc_out_stage and the defines header.
//
// Five-LED state-of-charge bar driver. Each input request is one 100 ms tick
// with state of charge, charge/discharge activity and undervoltage flags; each
// request yields exactly one result with the LED pattern and display mode as
// they stand after it. A request with tick low or bms_starting high changes
// nothing and repeats the current display. The block runs at one request per
// clock while its output register is not stalled: a request is registered on
// entry, the mode machine and LED update sit in one short logic level behind
// that register, and the result lands in an output register. An accepted
// request passes from the input register to the output register, where
// out_valid flags its result. While a result waits under out_stall, one
// further request is held in the input register; in_stall rises only when
// both registers are full. Modes: startup moves to normal on the first tick;
// normal shows SOC at 0/25/50/80 percent or blinks the lowest LED every fifth
// tick under undervoltage, then enters discharging (preferred) or charging on
// activity; charging shows 20 percent steps, blanking the current level for 5
// ticks and lighting all for 3; discharging shows 20 percent steps. Losing activity
// clears the bar and returns to normal. SOC above 100 is treated as 100.
`include "battery_soc_led_bar_controller_defines.svh"

module battery_soc_led_bar_controller
  import bslc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_tick,
  input  logic              in_bms_starting,
  input  logic [SOC_W-1:0]  in_soc_percent,
  input  logic              in_charge_active,
  input  logic              in_discharge_active,
  input  logic              in_cell_undervolt,
  input  logic              in_pack_undervolt,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LED_W-1:0]  out_led_pattern,
  output logic [MODE_W-1:0] out_display_mode
);

  bslc_item_t   in_item;
  bslc_item_t   item;
  logic         item_valid;
  logic         advance;
  logic         fire;
  bslc_result_t result_nxt;
  bslc_result_t result;
  bslc_status_t status;

  // Gather the request fields into one word for the input register.
  assign in_item = '{tick:             in_tick,
                     bms_starting:     in_bms_starting,
                     soc_percent:      in_soc_percent,
                     charge_active:    in_charge_active,
                     discharge_active: in_discharge_active,
                     cell_undervolt:   in_cell_undervolt,
                     pack_undervolt:   in_pack_undervolt};

  bslc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  // Commit the state update only when the held request moves to the output.
  assign fire = item_valid && advance;

  bslc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (item),
    .result_nxt (result_nxt),
    .status     (status)
  );

  bslc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result_nxt (result_nxt),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign out_led_pattern  = result.led_pattern;
  assign out_display_mode = result.display_mode;

  // Blink divider wraps at five, so it never exceeds four.
  `BSLC_ASSERT_ALWAYS(a_blink_range, status.blink < BLINK_TOP)
  // Charge animation phase never passes the end of the full-on window.
  `BSLC_ASSERT_ALWAYS(a_anim_range, status.anim <= ANIM_FULL_END)
  // Startup is left on the first tick, before any LED is driven.
  `BSLC_ASSERT_IMPLY(a_startup_dark, status.mode == MODE_STARTUP, status.led == '0)
  // Input side stalls only behind a full, stalled output register.
  `BSLC_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall && item_valid)

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for battery_soc_led_bar_controller: directed rows, then random requests.
// Depends on bslc_pkg and the controller RTL; a bar model predicts the results not given by hand.
module tb_top;
  import bslc_pkg::*;

  localparam int DIRECTED_N  = 24;
  localparam int RANDOM_N    = 850;
  localparam int CYCLE_LIMIT = 40000;
  localparam int HOLD_AT     = 300;   // request count that starts the long receiver hold
  localparam int HOLD_CYCLES = 60;
  localparam int QUIET_FROM  = 550;   // window with neither idle nor stall
  localparam int QUIET_TO    = 700;

  // One directed row: the request, plus a hand-written result where it is obvious.
  typedef struct {
    bslc_item_t   req;
    logic         typed;
    bslc_result_t want;
  } plan_row_t;

  typedef enum int {RUN_IDLE, RUN_CHARGE, RUN_DISCHARGE, RUN_UNDERVOLT, RUN_NOISE} run_kind_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_tick;
  logic              in_bms_starting;
  logic [SOC_W-1:0]  in_soc_percent;
  logic              in_charge_active;
  logic              in_discharge_active;
  logic              in_cell_undervolt;
  logic              in_pack_undervolt;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [LED_W-1:0]  out_led_pattern;
  logic [MODE_W-1:0] out_display_mode;

  // Model of the bar: mode machine, LEDs, blink divider and charge animation.
  logic [MODE_W-1:0] bar_mode;
  logic [LED_W-1:0]  bar_leds;
  logic [BLINK_W-1:0] blink_div;
  logic [ANIM_W-1:0] anim_phase;
  logic [LED_W-1:0]  anim_mask;

  // Results still owed by the block, oldest first.
  bslc_result_t display_q[$];

  int  errors          = 0;
  int  sent_count      = 0;
  int  checked_count   = 0;
  int  cycle_count     = 0;
  int  charge_ticks    = 0;
  int  discharge_ticks = 0;
  int  blink_toggles   = 0;
  logic hold_off       = 1'b0;
  logic quiet;

  // State-of-charge values sitting on every threshold edge, plus the clamp.
  int soc_edges[18] = '{0, 1, 19, 20, 24, 25, 39, 40, 49, 50, 59, 60, 79, 80, 99, 100, 101, 127};

  assign quiet = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);

  battery_soc_led_bar_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_tick             (in_tick),
    .in_bms_starting     (in_bms_starting),
    .in_soc_percent      (in_soc_percent),
    .in_charge_active    (in_charge_active),
    .in_discharge_active (in_discharge_active),
    .in_cell_undervolt   (in_cell_undervolt),
    .in_pack_undervolt   (in_pack_undervolt),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_led_pattern     (out_led_pattern),
    .out_display_mode    (out_display_mode)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Abort a hung run.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, display_q.size());
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 100) begin
      $display("mismatch at result %0d: %s got %0h want %0h", checked_count, what, got, want);
    end
  endtask

  // Advance the bar model by one accepted request.
  function automatic void advance_bar(input bslc_item_t req);
    logic [SOC_W-1:0] soc;
    logic             uv;
    logic [5:0]       level_bit;
    logic [LED_W-1:0] steps;
    // Anything above full scale reads as full.
    soc = (req.soc_percent > SOC_MAX) ? SOC_MAX : req.soc_percent;
    uv  = req.cell_undervolt | req.pack_undervolt;
    // No tick, or the battery system still starting: hold everything.
    if (!req.tick || req.bms_starting) return;
    case (bar_mode)
      MODE_STARTUP: bar_mode = MODE_NORMAL;
      MODE_NORMAL: begin
        if (uv) begin
          // Toggle the lowest LED every fifth tick, drop the three above it.
          blink_div = blink_div + 3'd1;
          if (blink_div >= BLINK_TOP) begin
            blink_div = '0;
            bar_leds  = {bar_leds[4], 3'b000, ~bar_leds[0]};
            blink_toggles++;
          end
        end else begin
          // Quarter thresholds; the top LED is left as it was.
          blink_div = '0;
          bar_leds  = {bar_leds[4], soc >= 80, soc >= 50, soc >= 25, soc != 0};
        end
        // Discharge takes priority when both are active.
        if (req.charge_active) bar_mode = MODE_CHARGE;
        if (req.discharge_active) bar_mode = MODE_DISCHARGE;
      end
      MODE_CHARGE: begin
        charge_ticks++;
        anim_phase = anim_phase + 4'd1;
        if (anim_phase <= ANIM_BLANK_END) begin
          // Blank the LED of the current level; at full level nothing is blanked.
          level_bit = 6'd1 << (soc / 20);
          anim_mask = ~level_bit[LED_W-1:0];
        end else begin
          anim_phase = anim_phase + 4'd1;
          if (anim_phase <= ANIM_FULL_END) anim_mask = LED_ALL;
          else anim_phase = '0;
        end
        steps    = {soc >= 80, soc >= 60, soc >= 40, soc >= 20, 1'b1};
        bar_leds = steps & anim_mask;
        if (!req.charge_active) begin
          bar_leds = '0;
          bar_mode = MODE_NORMAL;
        end
      end
      default: begin
        discharge_ticks++;
        bar_leds = {soc >= 80, soc >= 60, soc >= 40, soc >= 20, soc != 0};
        if (!req.discharge_active) begin
          bar_leds = '0;
          bar_mode = MODE_NORMAL;
        end
      end
    endcase
  endfunction

  // Offer one request; entered and left just after a falling edge.
  task automatic offer_request(input bslc_item_t req, input logic typed,
                               input bslc_result_t want);
    bslc_result_t owed;
    // Idle the sender now and then, but not inside the quiet window.
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_tick             = req.tick;
    in_bms_starting     = req.bms_starting;
    in_soc_percent      = req.soc_percent;
    in_charge_active    = req.charge_active;
    in_discharge_active = req.discharge_active;
    in_cell_undervolt   = req.cell_undervolt;
    in_pack_undervolt   = req.pack_undervolt;
    in_valid            = 1'b1;
    // Hold the payload until the block takes it.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_bar(req);
    owed.led_pattern  = bar_leds;
    owed.display_mode = bar_mode;
    display_q.push_back(typed ? want : owed);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic plan_row_t plan_row(input int tk, input int st, input int soc,
                                         input int ch, input int dc, input int cu,
                                         input int pu, input int typed,
                                         input logic [LED_W-1:0] led,
                                         input logic [MODE_W-1:0] mode);
    plan_row_t r;
    r.req.tick              = 1'(tk);
    r.req.bms_starting      = 1'(st);
    r.req.soc_percent       = soc[SOC_W-1:0];
    r.req.charge_active     = 1'(ch);
    r.req.discharge_active  = 1'(dc);
    r.req.cell_undervolt    = 1'(cu);
    r.req.pack_undervolt    = 1'(pu);
    r.typed                 = 1'(typed);
    r.want.led_pattern      = led;
    r.want.display_mode     = mode;
    return r;
  endfunction

  function automatic int pick_soc();
    if ($urandom_range(1) == 0) return soc_edges[$urandom_range(17)];
    return $urandom_range(127);
  endfunction

  // Receiver: stall at random, hold off for a long stretch once.
  always @(negedge clk) begin
    out_stall <= hold_off || (!quiet && $urandom_range(99) < 12);
  end

  // Long receiver hold while the sender keeps offering, so both stages fill.
  initial begin : long_hold
    wait (sent_count >= HOLD_AT);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Compare each accepted result with the oldest owed one.
  always @(posedge clk) begin : check_results
    bslc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (display_q.size() == 0) begin
        report_mismatch("result with nothing owed",
                        int'({out_led_pattern, out_display_mode}), 0);
      end else begin
        want = display_q.pop_front();
        if (out_led_pattern !== want.led_pattern) begin
          report_mismatch("led_pattern", int'(out_led_pattern), int'(want.led_pattern));
        end
        if (out_display_mode !== want.display_mode) begin
          report_mismatch("display_mode", int'(out_display_mode), int'(want.display_mode));
        end
      end
      checked_count++;
    end
  end

  initial begin : stimulus
    plan_row_t    plan[DIRECTED_N];
    bslc_item_t   req;
    bslc_result_t none;
    run_kind_t    kind;
    int           pick;
    int           run_len;
    int           soc;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_tick             = 1'b0;
    in_bms_starting     = 1'b0;
    in_soc_percent      = '0;
    in_charge_active    = 1'b0;
    in_discharge_active = 1'b0;
    in_cell_undervolt   = 1'b0;
    in_pack_undervolt   = 1'b0;
    none                = '0;

    bar_mode   = MODE_STARTUP;
    bar_leds   = '0;
    blink_div  = '0;
    anim_phase = '0;
    anim_mask  = '0;

    // Directed walk: hold cases, startup, normal extremes, undervolt blink,
    // charge animation at full and mid level, both-active priority, discharge
    // extremes and the exits back to normal.
    plan[0]  = plan_row(0, 0,  50, 0, 0, 0, 0, 1, 5'h00, MODE_STARTUP);
    plan[1]  = plan_row(1, 1,  50, 0, 0, 0, 0, 1, 5'h00, MODE_STARTUP);
    plan[2]  = plan_row(1, 0, 127, 1, 0, 0, 0, 1, 5'h00, MODE_NORMAL);
    plan[3]  = plan_row(1, 0, 127, 0, 0, 0, 0, 1, 5'h0F, MODE_NORMAL);
    plan[4]  = plan_row(1, 0,   0, 0, 0, 0, 0, 1, 5'h00, MODE_NORMAL);
    plan[5]  = plan_row(1, 0,  79, 0, 0, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[6]  = plan_row(1, 0,  80, 0, 0, 1, 0, 0, 5'h00, MODE_NORMAL);
    plan[7]  = plan_row(1, 0,  80, 0, 0, 0, 1, 0, 5'h00, MODE_NORMAL);
    plan[8]  = plan_row(1, 0,  80, 0, 0, 1, 1, 0, 5'h00, MODE_NORMAL);
    plan[9]  = plan_row(1, 0,  80, 0, 0, 1, 0, 0, 5'h00, MODE_NORMAL);
    plan[10] = plan_row(1, 0,  80, 0, 0, 0, 1, 0, 5'h00, MODE_NORMAL);
    plan[11] = plan_row(1, 0, 127, 1, 0, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[12] = plan_row(1, 1, 127, 1, 0, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[13] = plan_row(1, 0, 127, 1, 0, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[14] = plan_row(1, 0, 100, 1, 0, 1, 1, 0, 5'h00, MODE_NORMAL);
    plan[15] = plan_row(1, 0,  45, 1, 0, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[16] = plan_row(1, 0,  45, 1, 1, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[17] = plan_row(0, 0,  45, 0, 0, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[18] = plan_row(1, 0,  45, 0, 0, 0, 0, 1, 5'h00, MODE_NORMAL);
    plan[19] = plan_row(1, 0,  60, 1, 1, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[20] = plan_row(1, 0,   0, 0, 1, 0, 0, 1, 5'h00, MODE_DISCHARGE);
    plan[21] = plan_row(1, 0, 127, 0, 1, 1, 1, 1, 5'h1F, MODE_DISCHARGE);
    plan[22] = plan_row(0, 1,  10, 0, 0, 0, 0, 0, 5'h00, MODE_NORMAL);
    plan[23] = plan_row(1, 0,  50, 0, 0, 0, 0, 1, 5'h00, MODE_NORMAL);

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      offer_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    // Random part: runs of well-formed activity with random content, plus noise.
    while (sent_count < DIRECTED_N + RANDOM_N) begin
      pick = $urandom_range(99);
      if (pick < 30) kind = RUN_CHARGE;
      else if (pick < 55) kind = RUN_DISCHARGE;
      else if (pick < 75) kind = RUN_UNDERVOLT;
      else if (pick < 85) kind = RUN_IDLE;
      else kind = RUN_NOISE;
      run_len = $urandom_range(30, 4);
      soc     = pick_soc();
      for (int k = 0; k < run_len; k++) begin
        // Let the level drift inside a run.
        if ($urandom_range(3) == 0) soc = pick_soc();
        req                  = '0;
        req.tick             = ($urandom_range(99) < 88);
        req.bms_starting     = ($urandom_range(99) < 4);
        req.soc_percent      = soc[SOC_W-1:0];
        req.cell_undervolt   = ($urandom_range(99) < 5);
        req.pack_undervolt   = ($urandom_range(99) < 5);
        case (kind)
          RUN_CHARGE:    req.charge_active = 1'b1;
          RUN_DISCHARGE: req.discharge_active = 1'b1;
          RUN_UNDERVOLT: begin
            req.cell_undervolt = 1'($urandom_range(1));
            req.pack_undervolt = !req.cell_undervolt || $urandom_range(1);
          end
          RUN_NOISE: begin
            req.soc_percent      = 7'($urandom_range(127));
            req.charge_active    = 1'($urandom_range(1));
            req.discharge_active = 1'($urandom_range(1));
            req.cell_undervolt   = 1'($urandom_range(1));
            req.pack_undervolt   = 1'($urandom_range(1));
          end
          default: ;
        endcase
        // Occasionally break the run with a stray activity flip.
        if ($urandom_range(99) < 5) req.charge_active = ~req.charge_active;
        if ($urandom_range(99) < 5) req.discharge_active = ~req.discharge_active;
        offer_request(req, 1'b0, none);
      end
    end
    in_valid = 1'b0;

    // Drain, then keep clocking so that any stray result still shows.
    while (display_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d requests (%0d directed), %0d results checked, %0d mismatches",
             sent_count, DIRECTED_N, checked_count, errors);
    $display("charging ticks %0d, discharging ticks %0d, undervolt blink toggles %0d",
             charge_ticks, discharge_ticks, blink_toggles);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/bslc_pkg.sv
hdl/bslc_in_stage.sv
hdl/bslc_core.sv
hdl/bslc_out_stage.sv
hdl/battery_soc_led_bar_controller.sv
sim/tb_top.sv
